// ===== rtl/tpd_pkg.sv =====
// Shared constants, types and state encoding for the tolerance point dedup block.
`default_nettype none
package tpd_pkg;

    localparam int COORD_BITS  = 24;
    localparam int MAX_KEPT    = 1024;
    localparam int KEPT_IDX_W  = $clog2(MAX_KEPT);
    localparam int KEPT_CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int POINT_W     = 3 * COORD_BITS;
    localparam int TOL_W       = 23;
    localparam int STAT_W      = 20;
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int TOLSQ_W     = 2 * TOL_W;

    localparam int IN_TDATA_W  = ((POINT_W + 7) / 8) * 8;
    localparam int OUT_BITS    = POINT_W + 2 * STAT_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } tpd_state_t;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } tpd_cmd_t;

    typedef struct packed {
        logic tol_zero;
        logic store_empty;
        logic last_issue;
        logic hit;
        logic busy;
        logic out_free;
    } tpd_status_t;

endpackage
`default_nettype wire

// ===== rtl/tpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/tpd_ctrl.sv =====
// Controller state machine: sequences load, store scan and result commit.
`default_nettype none
module tpd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tpd_pkg::tpd_status_t status,
    output tpd_pkg::tpd_cmd_t         cmd
);

    tpd_pkg::tpd_state_t state_reg;
    tpd_pkg::tpd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tpd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            tpd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (status.tol_zero || status.store_empty)
                    begin
                        state_next = tpd_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = tpd_pkg::ST_SCAN;
                    end
                end
            end
            tpd_pkg::ST_SCAN:
            begin
                if (status.hit)
                begin
                    state_next = tpd_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    if (status.last_issue)
                    begin
                        state_next = tpd_pkg::ST_WAIT;
                    end
                end
            end
            tpd_pkg::ST_WAIT:
            begin
                // compare pipe drains; a hit or an empty pipe settles the point
                if (status.hit || !status.busy)
                begin
                    state_next = tpd_pkg::ST_FINISH;
                end
            end
            tpd_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = tpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tpd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/tpd_datapath.sv =====
// Datapath: point store, distance compare pipe, per-set counts and result register.
`default_nettype none
module tpd_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tpd_pkg::tpd_cmd_t                   cmd,
    output tpd_pkg::tpd_status_t                     status,
    input  wire logic                                cfg_we,
    input  wire logic        [tpd_pkg::TOL_W-1:0]    cfg_data,
    input  wire logic        [tpd_pkg::POINT_W-1:0]  in_point,
    input  wire logic                                in_last,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output logic                                     out_keep,
    output logic                                     out_full,
    output logic             [tpd_pkg::POINT_W-1:0]  out_point,
    output logic             [tpd_pkg::STAT_W-1:0]   out_seen,
    output logic             [tpd_pkg::STAT_W-1:0]   out_removed,
    output logic                                     out_done
);

    localparam int CB = tpd_pkg::COORD_BITS;

    function automatic logic [tpd_pkg::DIFF_W-1:0] abs_diff(
        input logic signed [tpd_pkg::COORD_BITS-1:0] a,
        input logic signed [tpd_pkg::COORD_BITS-1:0] b
    );
        logic signed [tpd_pkg::DIFF_W-1:0] d;
        d = tpd_pkg::DIFF_W'(a) - tpd_pkg::DIFF_W'(b);
        return d[tpd_pkg::DIFF_W-1] ? tpd_pkg::DIFF_W'(-d) : tpd_pkg::DIFF_W'(d);
    endfunction

    // configuration
    logic [tpd_pkg::TOL_W-1:0]   tol_reg;
    logic [tpd_pkg::TOLSQ_W-1:0] tol_sq_reg;

    // current point
    logic signed [CB-1:0] x_reg, y_reg, z_reg;
    logic                 last_reg;
    logic                 dup_reg;

    // set state
    logic [tpd_pkg::KEPT_CNT_W-1:0] kept_count_reg;
    logic [tpd_pkg::KEPT_CNT_W-1:0] rd_idx_reg;
    logic [tpd_pkg::STAT_W-1:0]     seen_count_reg;
    logic [tpd_pkg::STAT_W-1:0]     removed_count_reg;

    // compare pipe
    logic                         v1_reg, v2_reg, v3_reg, hit_reg;
    logic [tpd_pkg::DIFF_W-1:0]   ad_x_reg, ad_y_reg, ad_z_reg;
    logic [tpd_pkg::SQ_W-1:0]     sq_x_reg, sq_y_reg, sq_z_reg;
    logic [tpd_pkg::SUM_W-1:0]    dist_sq;
    logic [tpd_pkg::POINT_W-1:0]  kept_data;
    logic signed [CB-1:0]         kx, ky, kz;

    // commit values
    logic                           kept_full;
    logic                           store_we;
    logic [tpd_pkg::STAT_W-1:0]     seen_next;
    logic [tpd_pkg::STAT_W-1:0]     removed_next;
    logic [tpd_pkg::KEPT_CNT_W-1:0] kept_count_next;

    // result register
    logic                         out_valid_reg;
    logic                         out_keep_reg, out_full_reg, out_done_reg;
    logic [tpd_pkg::POINT_W-1:0]  out_point_reg;
    logic [tpd_pkg::STAT_W-1:0]   out_seen_reg, out_removed_reg;

    tpd_ram #(
        .WIDTH (tpd_pkg::POINT_W),
        .DEPTH (tpd_pkg::MAX_KEPT)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (kept_count_reg[tpd_pkg::KEPT_IDX_W-1:0]),
        .wdata ({z_reg, y_reg, x_reg}),
        .raddr (rd_idx_reg[tpd_pkg::KEPT_IDX_W-1:0]),
        .rdata (kept_data)
    );

    assign kx = kept_data[CB-1:0];
    assign ky = kept_data[2*CB-1:CB];
    assign kz = kept_data[3*CB-1:2*CB];

    assign dist_sq = tpd_pkg::SUM_W'(sq_x_reg) + tpd_pkg::SUM_W'(sq_y_reg)
                   + tpd_pkg::SUM_W'(sq_z_reg);

    assign kept_full = (kept_count_reg == tpd_pkg::KEPT_CNT_W'(tpd_pkg::MAX_KEPT));
    assign store_we  = cmd.commit && !dup_reg && !kept_full;
    assign seen_next = (seen_count_reg == tpd_pkg::STAT_MAX) ? seen_count_reg
                                                             : seen_count_reg + 1'b1;
    assign removed_next = (dup_reg && removed_count_reg != tpd_pkg::STAT_MAX)
                        ? removed_count_reg + 1'b1 : removed_count_reg;
    assign kept_count_next = store_we ? kept_count_reg + 1'b1 : kept_count_reg;

    assign status.tol_zero    = (tol_reg == '0);
    assign status.store_empty = (kept_count_reg == '0);
    assign status.last_issue  = (rd_idx_reg + 1'b1 == kept_count_reg);
    assign status.hit         = hit_reg;
    assign status.busy        = v1_reg || v2_reg || v3_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg           <= '0;
            kept_count_reg    <= '0;
            seen_count_reg    <= '0;
            removed_count_reg <= '0;
            rd_idx_reg        <= '0;
            dup_reg           <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            hit_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tol_reg <= cfg_data;
            end

            if (cmd.load)
            begin
                // flush anything left over from the previous point
                rd_idx_reg <= '0;
                dup_reg    <= 1'b0;
                v1_reg     <= 1'b0;
                v2_reg     <= 1'b0;
                v3_reg     <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                v1_reg  <= cmd.issue;
                v2_reg  <= v1_reg;
                v3_reg  <= v2_reg;
                hit_reg <= v3_reg && (dist_sq < tpd_pkg::SUM_W'(tol_sq_reg));
                dup_reg <= dup_reg || hit_reg;
            end

            if (cmd.commit)
            begin
                if (last_reg)
                begin
                    kept_count_reg    <= '0;
                    seen_count_reg    <= '0;
                    removed_count_reg <= '0;
                end
                else
                begin
                    kept_count_reg    <= kept_count_next;
                    seen_count_reg    <= seen_next;
                    removed_count_reg <= removed_next;
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tol_sq_reg <= tpd_pkg::TOLSQ_W'(tol_reg) * tpd_pkg::TOLSQ_W'(tol_reg);

        if (cmd.load)
        begin
            x_reg    <= in_point[CB-1:0];
            y_reg    <= in_point[2*CB-1:CB];
            z_reg    <= in_point[3*CB-1:2*CB];
            last_reg <= in_last;
        end

        ad_x_reg <= abs_diff(x_reg, kx);
        ad_y_reg <= abs_diff(y_reg, ky);
        ad_z_reg <= abs_diff(z_reg, kz);

        sq_x_reg <= tpd_pkg::SQ_W'(ad_x_reg) * tpd_pkg::SQ_W'(ad_x_reg);
        sq_y_reg <= tpd_pkg::SQ_W'(ad_y_reg) * tpd_pkg::SQ_W'(ad_y_reg);
        sq_z_reg <= tpd_pkg::SQ_W'(ad_z_reg) * tpd_pkg::SQ_W'(ad_z_reg);

        if (cmd.commit)
        begin
            out_keep_reg    <= !dup_reg;
            out_full_reg    <= !dup_reg && kept_full;
            out_point_reg   <= {z_reg, y_reg, x_reg};
            out_seen_reg    <= seen_next;
            out_removed_reg <= removed_next;
            out_done_reg    <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_keep    = out_keep_reg;
    assign out_full    = out_full_reg;
    assign out_point   = out_point_reg;
    assign out_seen    = out_seen_reg;
    assign out_removed = out_removed_reg;
    assign out_done    = out_done_reg;

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= tpd_pkg::KEPT_CNT_W'(tpd_pkg::MAX_KEPT))
        else $error("kept count beyond store depth");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> rd_idx_reg < kept_count_reg)
        else $error("store read past kept entries");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && last_reg |=>
            (kept_count_reg == '0 && seen_count_reg == '0 && removed_count_reg == '0))
        else $error("set state not cleared after last point");

    a_removed_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        removed_count_reg <= seen_count_reg)
        else $error("removed count exceeds seen count");

endmodule
`default_nettype wire

// ===== rtl/tolerance_point_dedup.sv =====
// Radius-based 3-D point deduplicator: top level, controller plus datapath.
//
// Input stream (s_axis): one point per transfer, tdata = {z, y, x} signed Q16.8,
// tlast marks the last point of a set. Output stream (m_axis): one result per
// point, tdata = {removed, seen, z, y, x}, tuser = {store_full, keep}, tlast = set done.
// cfg_we/cfg_data write the merge tolerance; write it only while the block is idle.
//
// A point is compared against every point stored so far in its set, one stored
// point per cycle through a four-stage read/abs/square/compare pipe on the
// store RAM. With N points stored the scan covers all N, ending sooner on a
// match; with zero tolerance or an empty store no scan is made at all. One
// point is in work at a time, so N sets the rate, up to 1024 stored points
// per set.
// The result sits in an output register; the next point is taken while it waits,
// and a stalled receiver only holds the block when the next result is ready.
// Reset clears the store count, the per-set counts, the tolerance and the
// output valid; the store itself needs no clearing.
`default_nettype none
module tolerance_point_dedup (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [tpd_pkg::TOL_W-1:0]           cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [tpd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // coord_x, coord_y, coord_z
    input  wire logic                                s_axis_tlast,  // last_point
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // out_x, out_y, out_z, points_seen, points_removed
    output logic      [tpd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic      [tpd_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // keep, store_full
    output logic                                     m_axis_tlast   // set_done
);

    tpd_pkg::tpd_cmd_t           cmd;
    tpd_pkg::tpd_status_t        status;
    logic                        res_keep, res_full, res_done;
    logic [tpd_pkg::POINT_W-1:0] res_point;
    logic [tpd_pkg::STAT_W-1:0]  res_seen, res_removed;

    tpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_point    (s_axis_tdata[tpd_pkg::POINT_W-1:0]),
        .in_last     (s_axis_tlast),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_keep    (res_keep),
        .out_full    (res_full),
        .out_point   (res_point),
        .out_seen    (res_seen),
        .out_removed (res_removed),
        .out_done    (res_done)
    );

    always_comb
    begin
        m_axis_tdata = '0;
        m_axis_tdata[tpd_pkg::POINT_W-1:0] = res_point;
        m_axis_tdata[tpd_pkg::POINT_W +: tpd_pkg::STAT_W] = res_seen;
        m_axis_tdata[tpd_pkg::POINT_W + tpd_pkg::STAT_W +: tpd_pkg::STAT_W] = res_removed;
        m_axis_tuser = {res_full, res_keep};
        m_axis_tlast = res_done;
    end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the radius-based point deduplicator.
module testbench;

    typedef struct packed {
        logic signed [tpd_pkg::COORD_BITS-1:0] z;
        logic signed [tpd_pkg::COORD_BITS-1:0] y;
        logic signed [tpd_pkg::COORD_BITS-1:0] x;
    } coords_t;

    typedef struct {
        logic                       keep;
        coords_t                    pt;
        logic                       full;
        logic [tpd_pkg::STAT_W-1:0] seen;
        logic [tpd_pkg::STAT_W-1:0] removed;
        logic                       done;
    } dedup_result_t;

    class dedup_scoreboard;
        coords_t                   stored[$];
        logic [tpd_pkg::TOL_W-1:0] tolerance;
        int unsigned               seen;
        int unsigned               removed;
        dedup_result_t             awaited[$];
        int unsigned               errors;
        int unsigned               points;
        int unsigned               sets;
        int unsigned               dups;
        int unsigned               overflows;

        function new();
            tolerance = '0;
            seen      = 0;
            removed   = 0;
            errors    = 0;
            points    = 0;
            sets      = 0;
            dups      = 0;
            overflows = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        // exact squared distance against tolerance squared
        function bit near(coords_t a, coords_t b);
            longint signed   dx;
            longint signed   dy;
            longint signed   dz;
            longint unsigned r;
            dx = longint'(a.x) - longint'(b.x);
            dy = longint'(a.y) - longint'(b.y);
            dz = longint'(a.z) - longint'(b.z);
            r  = 64'(tolerance);
            return longint'(dx * dx + dy * dy + dz * dz) < r * r;
        endfunction

        function void note_point(coords_t p, logic last);
            dedup_result_t r;
            bit            dup;
            dup = 0;
            if (tolerance != 0)
            begin
                foreach (stored[i])
                begin
                    if (near(p, stored[i]))
                    begin
                        dup = 1;
                        break;
                    end
                end
            end
            if (seen < tpd_pkg::STAT_MAX)
                seen++;
            r.full = 1'b0;
            if (dup)
            begin
                if (removed < tpd_pkg::STAT_MAX)
                    removed++;
                dups++;
            end
            else if (stored.size() < tpd_pkg::MAX_KEPT)
                stored.push_back(p);
            else
            begin
                r.full = 1'b1;
                overflows++;
            end
            r.keep    = !dup;
            r.pt      = p;
            r.seen    = tpd_pkg::STAT_W'(seen);
            r.removed = tpd_pkg::STAT_W'(removed);
            r.done    = last;
            awaited.push_back(r);
            points++;
            if (last)
            begin
                stored.delete();
                seen    = 0;
                removed = 0;
                sets++;
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [tpd_pkg::OUT_TDATA_W-1:0] data,
                                   logic [tpd_pkg::OUT_TUSER_W-1:0] user, logic last);
            dedup_result_t want;
            coords_t       got;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual tdata %h tuser %h tlast %b",
                         $time, data, user, last);
                return;
            end
            want = awaited.pop_front();
            got  = data[tpd_pkg::POINT_W-1:0];
            compare("keep", 64'(want.keep), 64'(user[0]));
            compare("out_x", 64'(want.pt.x), 64'(got.x));
            compare("out_y", 64'(want.pt.y), 64'(got.y));
            compare("out_z", 64'(want.pt.z), 64'(got.z));
            compare("store_full", 64'(want.full), 64'(user[1]));
            compare("points_seen", 64'(want.seen),
                    64'(data[tpd_pkg::POINT_W +: tpd_pkg::STAT_W]));
            compare("points_removed", 64'(want.removed),
                    64'(data[tpd_pkg::POINT_W+tpd_pkg::STAT_W +: tpd_pkg::STAT_W]));
            compare("set_done", 64'(want.done), 64'(last));
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [tpd_pkg::TOL_W-1:0]       cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [tpd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;  // coord_x, coord_y, coord_z
    logic                            s_axis_tlast = 1'b0; // last_point
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // out_x, out_y, out_z, points_seen, points_removed
    logic [tpd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic [tpd_pkg::OUT_TUSER_W-1:0] m_axis_tuser;        // keep, store_full
    logic                            m_axis_tlast;        // set_done

    bit              steady = 0;
    int unsigned     tol_writes = 0;
    coords_t         sent[$];
    dedup_scoreboard sb = new();

    tolerance_point_dedup i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic coords_t pt3(int px, int py, int pz);
        coords_t r;
        r.x = tpd_pkg::COORD_BITS'(px);
        r.y = tpd_pkg::COORD_BITS'(py);
        r.z = tpd_pkg::COORD_BITS'(pz);
        return r;
    endfunction

    function automatic coords_t rand_point();
        coords_t r;
        r.x = tpd_pkg::COORD_BITS'($urandom);
        r.y = tpd_pkg::COORD_BITS'($urandom);
        r.z = tpd_pkg::COORD_BITS'($urandom);
        return r;
    endfunction

    // Called at a clock edge; returns at the edge where the transfer happened.
    task automatic send_point(input coords_t p, input logic last);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_point(p, last);
        sent.push_back(p);
        if (sent.size() > 64)
            void'(sent.pop_front());
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [tpd_pkg::TOL_W-1:0] t);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= t;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.tolerance = t;
        tol_writes++;
    endtask

    // result side: random stall before each transfer
    initial
    begin
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial
    begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        coords_t                   centers[4];
        coords_t                   p;
        coords_t                   c;
        int unsigned               tol_span;
        int unsigned               random_items;
        int unsigned               set_len;
        int unsigned               pick;
        logic [tpd_pkg::TOL_W-1:0] tol;
        logic                      last;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero tolerance: everything kept, exact repeats included
        set_tolerance('0);
        send_point(pt3(8388607, 8388607, 8388607), 1'b0);
        send_point(pt3(-8388608, -8388608, -8388608), 1'b0);
        send_point(pt3(8388607, 8388607, 8388607), 1'b0);
        send_point(pt3(0, 0, 0), 1'b0);
        send_point(pt3(0, 0, 0), 1'b1);

        // one-unit radius: boundary along an axis and along a diagonal
        set_tolerance(tpd_pkg::TOL_W'(256));
        send_point(pt3(0, 0, 0), 1'b0);
        send_point(pt3(255, 0, 0), 1'b0);
        send_point(pt3(256, 0, 0), 1'b0);
        send_point(pt3(0, -181, 181), 1'b0);
        send_point(pt3(0, 182, 181), 1'b0);
        send_point(pt3(-128, -128, -128), 1'b0);
        send_point(pt3(-8388608, -8388608, -8388608), 1'b1);

        // largest radius still separates the corners and the origin
        set_tolerance('1);
        send_point(pt3(8388607, 8388607, 8388607), 1'b0);
        send_point(pt3(-8388608, -8388608, -8388608), 1'b0);
        send_point(pt3(0, 0, 0), 1'b0);
        send_point(pt3(1, -1, 1), 1'b0);

        // smallest radius, changed inside the set: only exact repeats merge
        set_tolerance(tpd_pkg::TOL_W'(1));
        send_point(pt3(0, 0, 0), 1'b0);
        send_point(pt3(0, 0, 1), 1'b1);

        // points stored under zero tolerance count once the radius is raised
        set_tolerance('0);
        send_point(pt3(1000, -2000, 3000), 1'b0);
        send_point(pt3(1000, -2000, 3000), 1'b0);
        set_tolerance(tpd_pkg::TOL_W'(512));
        send_point(pt3(1100, -2000, 3000), 1'b1);

        // overflow the store, then scan a full store
        set_tolerance('0);
        for (int i = 0; i < tpd_pkg::MAX_KEPT + 6; i++)
            send_point(rand_point(), 1'b0);
        set_tolerance(tpd_pkg::TOL_W'(4096));
        c = sent[sent.size()-7];  // last point that made it into the store
        p = sent[$];
        send_point(p, 1'b0);
        send_point(c, 1'b0);
        send_point(rand_point(), 1'b1);

        random_items = 0;
        set_len      = 0;
        while (random_items < 580)
        begin
            pick = $urandom_range(0, 9);
            tol  = (pick == 0) ? '0 :
                   (pick == 1) ? tpd_pkg::TOL_W'(1) :
                   (pick == 2) ? '1 :
                   (pick == 3) ? tpd_pkg::TOL_W'($urandom)
                               : tpd_pkg::TOL_W'($urandom_range(1, 2048));
            set_tolerance(tol);
            steady   = ($urandom_range(0, 3) == 0);
            tol_span = (tol == 0) ? 300 : ((tol > 4096) ? 4096 : 32'(tol));
            foreach (centers[k])
                centers[k] = rand_point();
            repeat ($urandom_range(20, 60))
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    // cluster around a center so the radius test is exercised
                    c   = centers[$urandom_range(0, 3)];
                    p.x = tpd_pkg::COORD_BITS'(int'(c.x) + int'($urandom_range(0, 2 * tol_span))
                                               - int'(tol_span));
                    p.y = tpd_pkg::COORD_BITS'(int'(c.y) + int'($urandom_range(0, 2 * tol_span))
                                               - int'(tol_span));
                    p.z = tpd_pkg::COORD_BITS'(int'(c.z) + int'($urandom_range(0, 2 * tol_span))
                                               - int'(tol_span));
                end
                else if (pick < 9)
                    p = sent[$urandom_range(0, sent.size() - 1)];
                else
                    p = rand_point();
                set_len++;
                last = ($urandom_range(0, 24) == 0) || (set_len >= 60);
                if (last)
                    set_len = 0;
                send_point(p, last);
                random_items++;
            end
        end

        steady = 0;
        drain();
        repeat (50) @(posedge clk);

        $display("Run covered %0d points in %0d closed sets under %0d radius settings;",
                 sb.points, sb.sets, tol_writes);
        $display("%0d points merged as duplicates, %0d kept past a full store.",
                 sb.dups, sb.overflows);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
